FILE: sv/ecpm_pkg.sv
package ecpm_pkg;

    localparam int POWER_W = 46;
    localparam int STATUS_W = 2;
    localparam int IN_ENERGY_W = 32;
    localparam int IN_TICK_W = 64;
    localparam int MIN_TICKS = 10;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRIMED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MEASURED = 2'd3;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_SHIFT  = 1'b1;

    typedef struct packed {
        logic [IN_ENERGY_W-1:0] energy_count;
        logic [IN_TICK_W-1:0]   tick_time;
    } in_t;

    typedef struct packed {
        logic [POWER_W-1:0]  power_milliwatts;
        logic [STATUS_W-1:0] status;
    } out_t;

endpackage

FILE: sv/ecpm_scale.sv
module ecpm_scale #(
    parameter int ENERGY_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [ENERGY_BITS-1:0]  d_energy,
    input  logic [4:0]              unit_shift,
    output logic                    done,
    output logic [ENERGY_BITS+19:0] scaled
);
    localparam int SW = ENERGY_BITS + 20;

    typedef enum logic [5:0] {
        SC_IDLE  = 6'b000001,
        SC_M1A   = 6'b000010,
        SC_M1B   = 6'b000100,
        SC_SHIFT = 6'b001000,
        SC_M2A   = 6'b010000,
        SC_M2B   = 6'b100000
    } scale_state_t;

    scale_state_t  state_reg, state_next;
    logic [SW-1:0] base_reg;
    logic [SW-1:0] acc_reg;
    logic [4:0]    shift_reg;
    logic          done_reg;

    always_comb begin
        case (state_reg)
            SC_IDLE:  state_next = start ? SC_M1A : SC_IDLE;
            SC_M1A:   state_next = SC_M1B;
            SC_M1B:   state_next = SC_SHIFT;
            SC_SHIFT: state_next = SC_M2A;
            SC_M2A:   state_next = SC_M2B;
            SC_M2B:   state_next = SC_IDLE;
            default:  state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SC_M2B);
        end
    end

    // times 1000 as (x << 10) - (x << 4) - (x << 3), split over the A and B states
    always_ff @(posedge aclk) begin
        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    base_reg  <= SW'(d_energy);
                    shift_reg <= unit_shift;
                end
            end
            SC_M1A, SC_M2A: begin
                acc_reg <= (base_reg << 10) - (base_reg << 4);
            end
            SC_M1B, SC_M2B: begin
                acc_reg <= acc_reg - (base_reg << 3);
            end
            SC_SHIFT: begin
                base_reg <= acc_reg >> shift_reg;
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign scaled = acc_reg;

endmodule

FILE: sv/ecpm_div.sv
module ecpm_div #(
    parameter int DIVIDEND_W = 52,
    parameter int DIVISOR_W  = 68
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    // one quotient bit per cycle, dividend shifts out msb first
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/energy_counter_power_meter_top.sv
// Average package power meter. Each input transaction carries an energy
// counter reading and a timer tick count (one tick is 10 ms) and gives
// exactly one result transaction: power in milliwatts and a status code
// (0 disabled, 1 first sample primed, 2 interval under 10 ticks, 3 measured).
// Power is ((((dE * 1000) >> energy_unit_shift) * 1000) / (dT * 10)), with dE
// taken modulo 2^ENERGY_BITS and dT modulo 2^TICK_BITS; the stored sample is
// replaced on priming and on every measurement. One sample is worked on at a
// time. Disabled, priming and short-interval samples go from S_CHECK straight
// to S_OUT; a measurement first passes through the constant-scaling sequence
// (M1A, M1B, SHIFT, M2A, M2B) and then the radix-2 divider, which produces one
// quotient bit per cycle. A new sample is accepted while the previous result
// still waits on the output register.
// Registers: meter_enable at address 0, energy_unit_shift at address 4.
module energy_counter_power_meter_top #(
    parameter int ENERGY_BITS = 32,
    parameter int TICK_BITS   = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ecpm_pkg::in_t                      s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ecpm_pkg::out_t                     m_payload,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ecpm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ecpm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ecpm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    localparam int SW = ENERGY_BITS + 20;
    localparam int DW = TICK_BITS + 4;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCALE  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic                             enable_reg;
    logic [4:0]                       unit_shift_reg;
    logic [ENERGY_BITS-1:0]           prev_energy_reg;
    logic [TICK_BITS-1:0]             prev_ticks_reg;
    logic                             primed_reg;
    logic [ENERGY_BITS-1:0]           energy_reg;
    logic [TICK_BITS-1:0]             ticks_reg;
    logic [TICK_BITS-1:0]             dt_reg;
    logic [DW-1:0]                    divisor_reg;
    logic [ecpm_pkg::STATUS_W-1:0]    status_reg;
    logic [ecpm_pkg::POWER_W-1:0]     power_reg;
    logic                             m_valid_reg;
    ecpm_pkg::out_t                   m_payload_reg;

    logic                             cfg_write;
    logic [ENERGY_BITS-1:0]           d_energy;
    logic [TICK_BITS-1:0]             d_ticks;
    logic                             too_short;
    logic                             measure;
    logic                             out_free;
    logic                             scale_start;
    logic                             scale_done;
    logic                             div_start;
    logic                             div_done;
    logic [SW-1:0]                    scaled;
    logic [SW-1:0]                    quotient;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            unit_shift_reg <= '0;
        end else if (cfg_write) begin
            case (paddr[2])
                ecpm_pkg::REG_ENABLE: enable_reg     <= pwdata[0];
                ecpm_pkg::REG_SHIFT:  unit_shift_reg <= pwdata[4:0];
                default:              enable_reg     <= enable_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ecpm_pkg::REG_ENABLE: prdata = {31'd0, enable_reg};
            ecpm_pkg::REG_SHIFT:  prdata = {27'd0, unit_shift_reg};
            default:              prdata = '0;
        endcase
    end

    assign d_energy  = energy_reg - prev_energy_reg;
    assign d_ticks   = ticks_reg - prev_ticks_reg;
    assign too_short = (d_ticks < TICK_BITS'(ecpm_pkg::MIN_TICKS));
    assign measure   = (state_reg == S_CHECK) && enable_reg && primed_reg && !too_short;
    assign out_free  = !m_valid_reg || m_ready;

    assign scale_start = measure;
    assign div_start   = (state_reg == S_SCALE) && scale_done;

    ecpm_scale #(
        .ENERGY_BITS(ENERGY_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scale_start),
        .d_energy   (d_energy),
        .unit_shift (unit_shift_reg),
        .done       (scale_done),
        .scaled     (scaled)
    );

    ecpm_div #(
        .DIVIDEND_W(SW),
        .DIVISOR_W (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scaled),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        case (state_reg)
            S_IDLE:   state_next = (s_valid && s_ready) ? S_CHECK : S_IDLE;
            S_CHECK:  state_next = measure ? S_SCALE : S_OUT;
            S_SCALE:  state_next = scale_done ? S_DIVIDE : S_SCALE;
            S_DIVIDE: state_next = div_done ? S_OUT : S_DIVIDE;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            primed_reg      <= 1'b0;
            prev_energy_reg <= '0;
            prev_ticks_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CHECK && enable_reg && (!primed_reg || !too_short)) begin
                prev_energy_reg <= energy_reg;
                prev_ticks_reg  <= ticks_reg;
                primed_reg      <= 1'b1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            energy_reg <= ENERGY_BITS'(s_payload.energy_count);
            ticks_reg  <= TICK_BITS'(s_payload.tick_time);
        end
        if (state_reg == S_CHECK) begin
            dt_reg    <= d_ticks;
            power_reg <= '0;
            if (!enable_reg) begin
                status_reg <= ecpm_pkg::STATUS_DISABLED;
            end else if (!primed_reg) begin
                status_reg <= ecpm_pkg::STATUS_PRIMED;
            end else if (too_short) begin
                status_reg <= ecpm_pkg::STATUS_SHORT;
            end else begin
                status_reg <= ecpm_pkg::STATUS_MEASURED;
            end
        end
        if (state_reg == S_SCALE) begin
            divisor_reg <= (DW'(dt_reg) << 3) + (DW'(dt_reg) << 1);
        end
        if (state_reg == S_DIVIDE && div_done) begin
            power_reg <= ecpm_pkg::POWER_W'(quotient);
        end
        if (state_reg == S_OUT && out_free) begin
            m_payload_reg.power_milliwatts <= power_reg;
            m_payload_reg.status           <= status_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

FILE: tb/sv/energy_counter_power_meter_checker.sv
`timescale 1ns / 1ps

module energy_counter_power_meter_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ecpm_pkg::in_t                   s_payload,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ecpm_pkg::out_t                  m_payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [ecpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ecpm_pkg::APB_DATA_W-1:0] pwdata,
    output int                              failures,
    output int                              pending
);

    localparam logic [127:0] MW_PER_W    = 128'd1000;
    localparam logic [127:0] MS_PER_TICK = 128'd10;
    localparam logic [63:0]  TICK_CEIL   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;

    ecpm_pkg::out_t                   expected_readings[$];
    int                               mismatch_count = 0;
    logic                             meter_on;
    logic [4:0]                       unit_shift;
    logic [ecpm_pkg::IN_ENERGY_W-1:0] last_energy;
    logic [ecpm_pkg::IN_TICK_W-1:0]   last_ticks;
    logic                             have_sample;

    assign failures = mismatch_count;

    function automatic ecpm_pkg::out_t predict_reading(input ecpm_pkg::in_t smp);
        ecpm_pkg::out_t                   r;
        logic [ecpm_pkg::IN_TICK_W-1:0]   dt;
        logic [ecpm_pkg::IN_ENERGY_W-1:0] de;
        logic [127:0]                     scaled;
        logic [127:0]                     quot;
        r.power_milliwatts = '0;
        r.status = ecpm_pkg::STATUS_DISABLED;
        if (!meter_on) begin
            return r;
        end
        if (!have_sample) begin
            last_energy = smp.energy_count;
            last_ticks = smp.tick_time;
            have_sample = 1'b1;
            r.status = ecpm_pkg::STATUS_PRIMED;
            return r;
        end
        dt = smp.tick_time - last_ticks;
        if (dt < ecpm_pkg::MIN_TICKS) begin
            r.status = ecpm_pkg::STATUS_SHORT;
            return r;
        end
        de = smp.energy_count - last_energy;
        scaled = ((128'(de) * MW_PER_W) >> unit_shift) * MW_PER_W;
        if (dt > TICK_CEIL) begin
            quot = '0;
        end else begin
            quot = scaled / (128'(dt) * MS_PER_TICK);
        end
        last_energy = smp.energy_count;
        last_ticks = smp.tick_time;
        r.power_milliwatts = quot[ecpm_pkg::POWER_W-1:0];
        r.status = ecpm_pkg::STATUS_MEASURED;
        return r;
    endfunction

    always @(posedge aclk) begin
        ecpm_pkg::out_t want;
        if (!aresetn) begin
            meter_on = 1'b0;
            unit_shift = '0;
            last_energy = '0;
            last_ticks = '0;
            have_sample = 1'b0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ecpm_pkg::REG_SHIFT) begin
                    unit_shift = pwdata[4:0];
                end else begin
                    meter_on = pwdata[0];
                end
            end
            if (s_valid && s_ready) begin
                expected_readings.push_back(predict_reading(s_payload));
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, expected none, got %0d / %0d",
                             $time, m_payload.power_milliwatts, m_payload.status);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_payload.power_milliwatts !== want.power_milliwatts) begin
                        mismatch_count++;
                        $display("%0t: power_milliwatts expected %0d, got %0d", $time,
                                 want.power_milliwatts, m_payload.power_milliwatts);
                    end
                    if (m_payload.status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, m_payload.status);
                    end
                end
            end
        end
        pending <= expected_readings.size();
    end

endmodule

FILE: tb/sv/energy_counter_power_meter_top_tb.sv
`timescale 1ns / 1ps

module energy_counter_power_meter_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 175;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    ecpm_pkg::in_t                   s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    ecpm_pkg::out_t                  m_payload;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ecpm_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ecpm_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ecpm_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int   failures;
    int   pending;
    int   cycles = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    bit   stall_req = 1'b0;
    bit   stall_ack = 1'b0;
    int   stall_left = 0;

    logic [ecpm_pkg::IN_ENERGY_W-1:0] cur_energy;
    logic [ecpm_pkg::IN_TICK_W-1:0]   cur_ticks;

    always #6 aclk = ~aclk;

    energy_counter_power_meter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    energy_counter_power_meter_checker power_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .failures  (failures),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random backpressure plus a single long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_req != stall_ack) begin
            stall_ack <= stall_req;
            stall_left <= 600;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(input logic idx,
                             input logic [ecpm_pkg::APB_DATA_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_sample(input logic [ecpm_pkg::IN_ENERGY_W-1:0] e,
                               input logic [ecpm_pkg::IN_TICK_W-1:0] t);
        int            gap;
        ecpm_pkg::in_t item;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.energy_count = e;
        item.tick_time = t;
        s_valid <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cur_energy = e;
        cur_ticks = t;
    endtask

    // mostly well-formed successive samples, some short intervals, some noise
    task automatic send_random_sample();
        int                               pick;
        logic [ecpm_pkg::IN_ENERGY_W-1:0] de;
        logic [ecpm_pkg::IN_TICK_W-1:0]   dt;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            case ($urandom_range(0, 3))
                0: de = $urandom_range(0, 255);
                1: de = $urandom_range(0, 1000000);
                default: de = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0: dt = {$urandom, $urandom} >> $urandom_range(0, 63);
                1: dt = 64'($urandom);
                default: dt = 64'($urandom_range(10, 5000));
            endcase
            if (dt < ecpm_pkg::MIN_TICKS) begin
                dt = 64'(ecpm_pkg::MIN_TICKS);
            end
            send_sample(cur_energy + de, cur_ticks + dt);
        end else if (pick < 85) begin
            send_sample(cur_energy + 32'($urandom_range(0, 5000)),
                        cur_ticks + 64'($urandom_range(0, 9)));
        end else begin
            send_sample($urandom, {$urandom, $urandom});
        end
    endtask

    initial begin
        cur_energy = '0;
        cur_ticks = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: disabled, priming, wraps, bounds of the tick delta
        write_reg(ecpm_pkg::REG_ENABLE, 32'hFFFF_FFFE);
        write_reg(ecpm_pkg::REG_SHIFT, 32'hFFFF_FFE0);
        send_sample(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(32'h0000_0000, 64'h0000_0000_0000_0000);
        write_reg(ecpm_pkg::REG_ENABLE, 32'h0000_0001);
        send_sample(32'hFFFF_FF00, 64'hFFFF_FFFF_FFFF_FFF8);
        send_sample(32'h0000_0100, 64'h0000_0000_0000_0001);
        send_sample(32'h0000_0100, 64'h0000_0000_0000_0002);
        send_sample(32'h0000_00FF, 64'h0000_0000_0000_000C);
        send_sample(32'h0000_00FF, 64'h0000_0000_0000_000C);
        send_sample(32'h1234_5678, 64'h8000_0000_0000_0000);
        send_sample(32'h1234_5678, 64'h8000_0000_0000_0010);
        send_sample(32'h9234_5678, 64'h8000_0000_0000_0010 + 64'h1999_9999_9999_9999);
        send_sample(32'h1234_5678, cur_ticks + 64'h1999_9999_9999_999A);
        send_sample(32'hAAAA_AAAA, ~cur_ticks);
        write_reg(ecpm_pkg::REG_SHIFT, 32'h0000_001F);
        send_sample(cur_energy + 32'hFFFF_FFFF, cur_ticks + 64'd10);
        send_sample(cur_energy + 32'h5555_5555, cur_ticks + 64'd11);
        write_reg(ecpm_pkg::REG_SHIFT, 32'hFFFF_FFE7);
        send_sample(cur_energy + 32'h0000_0001, cur_ticks + 64'd10);
        send_sample(cur_energy + 32'h7FFF_FFFF, cur_ticks + 64'd1000);
        write_reg(ecpm_pkg::REG_ENABLE, 32'h0000_0000);
        send_sample(32'h0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
        write_reg(ecpm_pkg::REG_ENABLE, 32'hFFFF_FFFF);
        send_sample(cur_energy + 32'd1000, cur_ticks + 64'd100);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_reg(ecpm_pkg::REG_SHIFT, 32'h0000_0000);
                    tx_idle_pct = 36;
                    rx_idle_pct = 55;
                end
                1: begin
                    write_reg(ecpm_pkg::REG_SHIFT, 32'($urandom_range(1, 30)));
                    write_reg(ecpm_pkg::REG_ENABLE, 32'h0000_0000);
                    tx_idle_pct = 55;
                    rx_idle_pct = 36;
                    repeat (8) send_random_sample();
                    write_reg(ecpm_pkg::REG_ENABLE, 32'h0000_0001);
                end
                default: begin
                    write_reg(ecpm_pkg::REG_SHIFT, 32'h0000_001F);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    stall_req = ~stall_req;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 100) begin
                    write_reg(ecpm_pkg::REG_SHIFT, 32'($urandom));
                end
                send_random_sample();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
